[src/slbm_pkg.sv]
// Types and constants shared by the serial loaded bank mapper.
// Holds the beat structs and the target, register-select and PRG layout codes.
// No dependencies.
package slbm_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  target;
        logic [17:0] rom_offset;
        logic [7:0]  read_data;
        logic [1:0]  mirroring;
    } t_out_beat;

    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_CHR_ROM = 2'd1;
    localparam logic [1:0] TGT_PRG_ROM = 2'd2;
    localparam logic [1:0] TGT_PRG_RAM = 2'd3;

    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_CHR_LOW  = 2'd1;
    localparam logic [1:0] REG_CHR_HIGH = 2'd2;
    localparam logic [1:0] REG_PRG      = 2'd3;

    localparam logic [1:0] PRG_LAYOUT_FIXED_FIRST = 2'd2;
    localparam logic [1:0] PRG_LAYOUT_FIXED_LAST  = 2'd3;

    localparam logic [1:0] MIR_SINGLE     = 2'd0;
    localparam logic [1:0] MIR_VERTICAL   = 2'd1;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd2;

    localparam logic       MODE_WRITE     = 1'b1;
    localparam logic [2:0] SHIFT_BITS     = 3'd5;
    localparam logic [4:0] BANK_COUNT_RST = 5'd2;

endpackage

[src/serial_loaded_bank_mapper.sv]
// Serial loaded bank mapper: bank registers, address translation, 8 KiB PRG RAM.
// Beats pass register s1, then the output register; one beat per cycle unless
// the output stalls; set by the single-port PRG RAM read and a two-entry pipe.
// Reset clears the shift register, bank registers and pipe; bank count resets to 2.
// PRG RAM contents are undefined until written; no clearing pass.
// Depends on slbm_pkg.
module serial_loaded_bank_mapper #(
    parameter int RAM_BYTES = 8192
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  slbm_pkg::t_in_beat     i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output slbm_pkg::t_out_beat    o_out,
    input  logic                   i_cfg_we,
    input  logic [4:0]             i_cfg_wdata
);
    import slbm_pkg::*;

    localparam int RamAw = $clog2(RAM_BYTES);

    logic [7:0] r_ram [RAM_BYTES];
    logic [7:0] r_ram_q;

    logic [4:0] r_bank_count;
    logic [4:0] r_shift_value, n_shift_value;
    logic [2:0] r_shift_count, n_shift_count;
    logic [4:0] r_control, n_control;
    logic [4:0] r_chr_low, n_chr_low;
    logic [4:0] r_chr_high, n_chr_high;
    logic [4:0] r_prg_sel, n_prg_sel;

    logic       r_s1_valid;
    t_out_beat  r_s1, n_s1;
    logic       r_out_valid;
    t_out_beat  r_out, n_out;

    logic       in_accept, out_free, s1_move;
    logic       is_write, is_prg, is_ram, is_chr;
    logic [RamAw-1:0] ram_idx;
    logic [4:0] shifted;
    logic [2:0] count_inc;
    logic [3:0] last_bank;
    logic [14:0] prg_a;
    logic [1:0] prg_layout;
    logic [4:0] chr_bank;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_move     = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign is_write = (i_in.mode == MODE_WRITE);
    assign is_prg   = i_in.address[15];
    assign is_ram   = (i_in.address[15:13] == 3'b011);
    assign is_chr   = (i_in.address[15:13] == 3'b000);
    assign ram_idx  = i_in.address[RamAw-1:0];

    // serial load
    always_comb begin
        n_shift_value = r_shift_value;
        n_shift_count = r_shift_count;
        n_control     = r_control;
        n_chr_low     = r_chr_low;
        n_chr_high    = r_chr_high;
        n_prg_sel     = r_prg_sel;
        shifted       = r_shift_value | (5'(i_in.data[0]) << r_shift_count);
        count_inc     = r_shift_count + 3'd1;
        if (in_accept && is_write && is_prg) begin
            if (i_in.data[7]) begin
                n_shift_value = '0;
                n_shift_count = '0;
            end else if (count_inc >= SHIFT_BITS) begin
                n_shift_value = '0;
                n_shift_count = '0;
                unique case (i_in.address[14:13])
                    REG_CONTROL:  n_control  = shifted;
                    REG_CHR_LOW:  n_chr_low  = shifted;
                    REG_CHR_HIGH: n_chr_high = shifted;
                    REG_PRG:      n_prg_sel  = shifted;
                    default:      n_prg_sel  = shifted;
                endcase
            end else begin
                n_shift_value = shifted;
                n_shift_count = count_inc;
            end
        end
    end

    // address translation
    always_comb begin
        last_bank  = 4'(r_bank_count - 5'd1);
        prg_a      = i_in.address[14:0];
        prg_layout = r_control[3:2];
        chr_bank   = i_in.address[12] ? r_chr_high : r_chr_low;
        n_s1           = '0;
        n_s1.mirroring = MIR_SINGLE;
        case (n_control[1:0])
            2'd2:    n_s1.mirroring = MIR_VERTICAL;
            2'd3:    n_s1.mirroring = MIR_HORIZONTAL;
            default: n_s1.mirroring = MIR_SINGLE;
        endcase
        if (!is_write) begin
            if (is_chr) begin
                n_s1.target = TGT_CHR_ROM;
                if (r_control[4]) begin
                    n_s1.rom_offset = 18'({chr_bank, i_in.address[11:0]});
                end else begin
                    n_s1.rom_offset = 18'({r_chr_low[4:1], i_in.address[12:0]});
                end
            end else if (is_prg) begin
                n_s1.target = TGT_PRG_ROM;
                if (prg_layout == PRG_LAYOUT_FIXED_FIRST) begin
                    n_s1.rom_offset = prg_a[14] ? 18'({r_prg_sel[3:0], prg_a[13:0]})
                                                : 18'(prg_a);
                end else if (prg_layout == PRG_LAYOUT_FIXED_LAST) begin
                    n_s1.rom_offset = prg_a[14] ? 18'({last_bank, prg_a[13:0]})
                                                : 18'({r_prg_sel[3:0], prg_a[13:0]});
                end else begin
                    n_s1.rom_offset = {r_prg_sel[3:1], prg_a};
                end
            end else if (is_ram) begin
                n_s1.target = TGT_PRG_RAM;
            end
        end
    end

    always_comb begin
        n_out           = r_s1;
        n_out.read_data = (r_s1.target == TGT_PRG_RAM) ? r_ram_q : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_write && is_ram) begin
            r_ram[ram_idx] <= i_in.data;
        end
        if (in_accept && !is_write) begin
            r_ram_q <= r_ram[ram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count  <= BANK_COUNT_RST;
            r_shift_value <= '0;
            r_shift_count <= '0;
            r_control     <= '0;
            r_chr_low     <= '0;
            r_chr_high    <= '0;
            r_prg_sel     <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bank_count <= i_cfg_wdata;
            end
            r_shift_value <= n_shift_value;
            r_shift_count <= n_shift_count;
            r_control     <= n_control;
            r_chr_low     <= n_chr_low;
            r_chr_high    <= n_chr_high;
            r_prg_sel     <= n_prg_sel;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

endmodule

[bench/tb_serial_loaded_bank_mapper.sv]
// Self-checking bench for serial_loaded_bank_mapper: random bus traffic with idling on both
// sides, an in-bench mapper model, and in-order comparison of every result beat.
// Depends on slbm_pkg and the mapper RTL.
module tb_serial_loaded_bank_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import slbm_pkg::*;

    localparam int          RAM_BYTES    = 8192;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam logic        MODE_READ    = ~MODE_WRITE;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_beat            i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_beat           o_out;
    logic                i_cfg_we    = 1'b0;
    logic [4:0]          i_cfg_wdata = '0;

    serial_loaded_bank_mapper #(.RAM_BYTES(RAM_BYTES)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mapper model state
    logic [4:0] sr_bits      = '0;
    logic [2:0] sr_count     = '0;
    logic [4:0] ctrl_q       = '0;
    logic [4:0] chr_bank_lo  = '0;
    logic [4:0] chr_bank_hi  = '0;
    logic [4:0] prg_bank_sel = '0;
    logic [4:0] bank_count   = BANK_COUNT_RST;
    logic [7:0] prg_ram [RAM_BYTES];

    t_in_beat    pending_beats[$];
    t_out_beat   expected_results[$];
    t_out_beat   want;
    int unsigned beats_offered, beats_taken, results_taken, results_seen;
    int unsigned mismatches, useful_queued, settings_used;
    int          gap_left, stall_left;
    bit          sending;
    int unsigned cycles;

    // generator-side record of PRG RAM bytes already written
    bit          ram_seen [RAM_BYTES];
    logic [12:0] ram_filled[$];

    function automatic t_out_beat map_access(input t_in_beat b);
        t_out_beat   r;
        logic [14:0] a;
        logic [4:0]  bank;
        logic [3:0]  last;
        r = '0;
        a = b.address[14:0];
        if (b.mode == MODE_WRITE) begin
            if (b.address[15]) begin
                if (b.data[7]) begin
                    sr_bits  = '0;
                    sr_count = '0;
                end else begin
                    sr_bits[sr_count] = b.data[0];
                    sr_count++;
                    if (sr_count >= SHIFT_BITS) begin
                        case (b.address[14:13])
                            REG_CONTROL:  ctrl_q       = sr_bits;
                            REG_CHR_LOW:  chr_bank_lo  = sr_bits;
                            REG_CHR_HIGH: chr_bank_hi  = sr_bits;
                            default:      prg_bank_sel = sr_bits;
                        endcase
                        sr_bits  = '0;
                        sr_count = '0;
                    end
                end
            end else if (b.address >= 16'h6000) begin
                prg_ram[b.address[12:0]] = b.data;
            end
        end else if (b.address < 16'h2000) begin
            r.target = TGT_CHR_ROM;
            if (ctrl_q[4]) begin
                bank = b.address[12] ? chr_bank_hi : chr_bank_lo;
                r.rom_offset = 18'({bank, b.address[11:0]});
            end else begin
                r.rom_offset = 18'({chr_bank_lo[4:1], b.address[12:0]});
            end
        end else if (b.address[15]) begin
            r.target = TGT_PRG_ROM;
            last = 4'(bank_count - 5'd1);
            case (ctrl_q[3:2])
                PRG_LAYOUT_FIXED_FIRST: begin
                    r.rom_offset = a[14] ? {prg_bank_sel[3:0], a[13:0]} : {4'd0, a[13:0]};
                end
                PRG_LAYOUT_FIXED_LAST: begin
                    r.rom_offset = a[14] ? {last, a[13:0]} : {prg_bank_sel[3:0], a[13:0]};
                end
                default: r.rom_offset = {prg_bank_sel[3:1], a};
            endcase
        end else if (b.address >= 16'h6000) begin
            r.target    = TGT_PRG_RAM;
            r.read_data = prg_ram[b.address[12:0]];
        end
        case (ctrl_q[1:0])
            2'd2:    r.mirroring = MIR_VERTICAL;
            2'd3:    r.mirroring = MIR_HORIZONTAL;
            default: r.mirroring = MIR_SINGLE;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // monitor: input and output beats sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(map_access(i_in));
                beats_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_taken++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %p", $time, o_out);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("target", want.target, o_out.target);
                    check_field("rom_offset", want.rom_offset, o_out.rom_offset);
                    check_field("read_data", want.read_data, o_out.read_data);
                    check_field("mirroring", want.mirroring, o_out.mirroring);
                end
            end
        end
    end

    // driver: one beat at a time from the pending queue, random gaps, some stretches without
    always @(negedge i_clk) begin
        if (sending && beats_taken == beats_offered) begin
            sending  = 1'b0;
            gap_left = ((beats_offered % 512) >= 64) ? $urandom_range(0, 4) : 0;
        end
        if (!sending && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats.size() != 0) begin
                i_in <= pending_beats.pop_front();
                sending = 1'b1;
                beats_offered++;
            end
        end
        i_in_valid <= sending;
    end

    // result side stall, redrawn after every accepted beat
    always @(negedge i_clk) begin
        if (results_seen != results_taken) begin
            results_seen = results_taken;
            stall_left   = ((results_taken % 512) >= 64) ? $urandom_range(0, 4) : 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic queue_access(input logic mode, input logic [15:0] addr, input logic [7:0] data);
        t_in_beat b;
        b.mode    = mode;
        b.address = addr;
        b.data    = data;
        pending_beats.push_back(b);
        if (mode == MODE_WRITE && addr >= 16'h6000 && addr < 16'h8000 && !ram_seen[addr[12:0]]) begin
            ram_seen[addr[12:0]] = 1'b1;
            ram_filled.push_back(addr[12:0]);
        end
        if (!(mode == MODE_WRITE && addr < 16'h6000))
            useful_queued++;
    endtask

    task automatic random_read();
        logic [15:0] addr;
        case ($urandom_range(0, 3))
            0:       addr = 16'($urandom_range(0, 16'h1fff));
            1:       addr = {1'b1, 15'($urandom)};
            2:       addr = (ram_filled.size() != 0)
                          ? {3'b011, ram_filled[$urandom_range(0, ram_filled.size() - 1)]}
                          : 16'($urandom_range(16'h2000, 16'h5fff));
            default: addr = 16'($urandom_range(16'h2000, 16'h5fff));
        endcase
        queue_access(MODE_READ, addr, 8'($urandom));
    endtask

    task automatic random_traffic(input int n);
        int          goal, pick, k, len;
        logic [4:0]  value;
        goal = useful_queued + n;
        while (useful_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                value = 5'($urandom);
                for (k = 0; k < 5; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        random_read();
                    queue_access(MODE_WRITE, {1'b1, 15'($urandom)},
                                 {1'b0, 6'($urandom), value[k]});
                end
            end else if (pick < 46) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    queue_access(MODE_WRITE, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
                queue_access(MODE_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
            end else if (pick < 80) begin
                random_read();
            end else if (pick < 92) begin
                queue_access(MODE_WRITE, {3'b011, 13'($urandom)}, 8'($urandom));
            end else if (pick < 96) begin
                queue_access(MODE_WRITE, 16'($urandom_range(0, 16'h5fff)), 8'($urandom));
            end else begin
                queue_access(MODE_WRITE, {1'b1, 15'($urandom)}, 8'($urandom));
            end
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || sending || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_bank_count(input logic [4:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        bank_count  = value;
        settings_used++;
    endtask

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [4:0] counts [8];
        int p;
        counts = '{5'd2, 5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd0, 5'd0};
        counts[6] = 5'($urandom);
        counts[7] = 5'($urandom);
        settings_used = 1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // edges of every address window, RAM, ignored write, clear, full control load
        queue_access(MODE_READ, 16'h0000, 8'h00);
        queue_access(MODE_READ, 16'h1fff, 8'hff);
        queue_access(MODE_READ, 16'h2000, 8'h00);
        queue_access(MODE_READ, 16'h5fff, 8'h00);
        queue_access(MODE_READ, 16'h8000, 8'h00);
        queue_access(MODE_READ, 16'hffff, 8'h00);
        queue_access(MODE_WRITE, 16'h6000, 8'hff);
        queue_access(MODE_WRITE, 16'h7fff, 8'h00);
        queue_access(MODE_READ, 16'h6000, 8'h00);
        queue_access(MODE_READ, 16'h7fff, 8'hff);
        queue_access(MODE_WRITE, 16'h0000, 8'hff);
        queue_access(MODE_WRITE, 16'h8000, 8'h01);
        queue_access(MODE_WRITE, 16'hffff, 8'h80);
        repeat (5) queue_access(MODE_WRITE, 16'h9fff, 8'h7f);
        queue_access(MODE_READ, 16'hbfff, 8'h00);
        queue_access(MODE_READ, 16'hc000, 8'h00);
        queue_access(MODE_READ, 16'h1000, 8'h00);

        for (p = 0; p < 8; p++) begin
            if (p != 0)
                write_bank_count(counts[p]);
            random_traffic(210);
        end

        drain();
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            mismatches++;
        end
        $display("run covered %0d bus accesses and %0d checked results", beats_taken,
                 results_taken);
        $display("across %0d bank count settings, %0d mismatches", settings_used, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[serial_loaded_bank_mapper.f]
src/slbm_pkg.sv
src/serial_loaded_bank_mapper.sv
bench/tb_serial_loaded_bank_mapper.sv
